@@ rtl/mts_pkg.sv @@
`timescale 1ns / 1ps

package mts_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type             req_type;
      logic signed [31:0] value;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] min_value;
      logic               min_valid;
      logic [CNT_W-1:0]   depth;
      status_type         status;
   } rsp_beat_type;

endpackage

@@ rtl/min_tracking_stack_top.sv @@
`timescale 1ns / 1ps

// Bounded LIFO of signed values that returns one response beat per request beat: the
// current minimum (zero with min_valid low when empty), the depth and a status. A push or
// a pop can be taken every cycle while req_ready is high and its response is registered;
// both stack tops live in registers, and each stack memory is read one entry ahead at the
// address below the new top, so a pop always finds the next top already in a register. Two
// response beats are buffered, so req_ready drops only when both are waiting. The stack
// memories need no clearing after reset: no entry above the fill counts reaches a response.
module min_tracking_stack_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mts_pkg::req_beat_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mts_pkg::rsp_beat_type rsp_data
);
   import mts_pkg::*;

   data_type         main_mem [STACK_DEPTH];
   data_type         min_mem  [STACK_DEPTH];

   logic [CNT_W-1:0] main_cnt_ff, main_cnt_in;
   logic [CNT_W-1:0] min_cnt_ff, min_cnt_in;
   data_type         main_top_ff, main_top_in;
   data_type         min_top_ff, min_top_in;
   data_type         main_next_ff;
   data_type         min_next_ff;

   logic             req_accept;
   logic             main_wr;
   logic             min_wr;
   data_type         push_val;
   status_type       status_in;
   logic [CNT_W-1:0] main_below;
   logic [CNT_W-1:0] min_below;
   rsp_beat_type     rsp_new;

   rsp_beat_type     buf_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             rsp_accept;

   assign req_ready  = (fill_ff != 2'd2);
   assign req_accept = req_valid & req_ready;
   assign rsp_valid  = (fill_ff != 2'd0);
   assign rsp_accept = rsp_valid & rsp_ready;
   assign rsp_data   = buf_ff[rd_ptr_ff];
   assign push_val   = data_type'(req_data.value);

   always_comb begin
      main_cnt_in = main_cnt_ff;
      min_cnt_in  = min_cnt_ff;
      main_top_in = main_top_ff;
      min_top_in  = min_top_ff;
      main_wr     = 1'b0;
      min_wr      = 1'b0;
      status_in   = STATUS_OK;
      if (req_accept) begin
         unique case (req_data.req_type)
            OP_PUSH: begin
               if (main_cnt_ff == CNT_W'(STACK_DEPTH)) begin
                  status_in = STATUS_FULL;
               end else begin
                  main_wr     = 1'b1;
                  main_cnt_in = main_cnt_ff + CNT_W'(1);
                  main_top_in = push_val;
                  if ((min_cnt_ff == '0 || push_val <= min_top_ff) &&
                      min_cnt_ff < CNT_W'(STACK_DEPTH)) begin
                     min_wr     = 1'b1;
                     min_cnt_in = min_cnt_ff + CNT_W'(1);
                     min_top_in = push_val;
                  end
               end
            end
            OP_POP: begin
               if (main_cnt_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  main_cnt_in = main_cnt_ff - CNT_W'(1);
                  main_top_in = main_next_ff;
                  if (min_cnt_ff != '0 && main_top_ff == min_top_ff) begin
                     min_cnt_in = min_cnt_ff - CNT_W'(1);
                     min_top_in = min_next_ff;
                  end
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   assign main_below = main_cnt_in - CNT_W'(2);
   assign min_below  = min_cnt_in - CNT_W'(2);

   always_comb begin
      rsp_new.min_valid = (min_cnt_in != '0);
      rsp_new.min_value = (min_cnt_in != '0) ? 32'(min_top_in) : '0;
      rsp_new.depth     = main_cnt_in;
      rsp_new.status    = status_in;
   end

   always_ff @(posedge clock) begin
      if (main_wr) begin
         main_mem[main_cnt_ff[ADDR_W-1:0]] <= push_val;
      end
      main_next_ff <= main_mem[main_below[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (min_wr) begin
         min_mem[min_cnt_ff[ADDR_W-1:0]] <= push_val;
      end
      min_next_ff <= min_mem[min_below[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      main_top_ff <= main_top_in;
      min_top_ff  <= min_top_in;
      if (req_accept) begin
         buf_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ req_accept;
      rd_ptr_in = rd_ptr_ff ^ rsp_accept;
      fill_in   = fill_ff + 2'(req_accept) - 2'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_cnt_ff <= '0;
         min_cnt_ff  <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         fill_ff     <= 2'd0;
      end else begin
         main_cnt_ff <= main_cnt_in;
         min_cnt_ff  <= min_cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      min_cnt_ff <= main_cnt_ff)
      else $error("minimum stack deeper than main stack");

   assert property (@(posedge clock) disable iff (reset)
      main_cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("main stack count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      (main_cnt_ff != '0) |-> (min_cnt_ff != '0))
      else $error("nonempty stack without a minimum");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'd2)
      else $error("response buffer overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL) |-> (rsp_data.depth == CNT_W'(STACK_DEPTH)))
      else $error("dropped push reported below capacity");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import mts_pkg::*;

   localparam int HOLD_TAIL = 20;
   localparam int MAX_REPORTS = 40;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   min_tracking_stack_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   req_beat_type pending_ops[$];
   rsp_beat_type pending_reports[$];

   data_type shadow_vals[STACK_DEPTH];
   data_type shadow_mins[STACK_DEPTH];
   int shadow_depth = 0;
   int shadow_min_depth = 0;

   int total_ops = 0;
   int directed_ops = 0;
   int sent_count = 0;
   int rsp_count = 0;
   int errors = 0;
   int push_count = 0;
   int pop_count = 0;
   int full_hits = 0;
   int empty_hits = 0;
   int deepest = 0;

   logic [3:0] gap_left = '0;
   logic [3:0] stall_left = '0;
   logic send_idle = 1'b1;
   logic take_idle = 1'b1;

   function automatic rsp_beat_type apply_op(req_beat_type op);
      rsp_beat_type r;
      data_type v;
      data_type top;
      r = '0;
      r.status = STATUS_OK;
      v = data_type'(op.value);
      if (op.req_type == OP_PUSH) begin
         if (shadow_depth >= STACK_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            shadow_vals[shadow_depth] = v;
            shadow_depth++;
            if (shadow_min_depth == 0 || v <= shadow_mins[shadow_min_depth-1]) begin
               shadow_mins[shadow_min_depth] = v;
               shadow_min_depth++;
            end
         end
      end else begin
         if (shadow_depth == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            shadow_depth--;
            top = shadow_vals[shadow_depth];
            if (shadow_min_depth > 0 && top == shadow_mins[shadow_min_depth-1])
               shadow_min_depth--;
         end
      end
      if (shadow_min_depth > 0) begin
         r.min_value = shadow_mins[shadow_min_depth-1];
         r.min_valid = 1'b1;
      end
      r.depth = CNT_W'(shadow_depth);
      return r;
   endfunction

   function automatic data_type draw_value();
      data_type v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
               1: v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
               2: v = '0;
               default: v = '1;
            endcase
         end
         1, 2, 3, 4: v = data_type'($urandom_range(0, 20)) - data_type'(10);
         default: v = data_type'($urandom);
      endcase
      return v;
   endfunction

   task automatic add_op(op_type kind, data_type v);
      req_beat_type op;
      op.req_type = kind;
      op.value = v;
      pending_ops.push_back(op);
   endtask

   task automatic build_ops(int target);
      int burst;
      int push_pct;
      add_op(OP_POP, 32'sd77);
      add_op(OP_PUSH, 32'sh7fffffff);
      add_op(OP_PUSH, 32'sh80000000);
      add_op(OP_PUSH, 32'sh80000000);
      add_op(OP_PUSH, -32'sd1);
      add_op(OP_PUSH, 32'sd0);
      add_op(OP_PUSH, 32'sd5);
      repeat (7) add_op(OP_POP, 32'sh5555aaaa);
      add_op(OP_PUSH, 32'sd3);
      add_op(OP_PUSH, 32'sd3);
      add_op(OP_PUSH, 32'sd2);
      add_op(OP_PUSH, 32'sd4);
      repeat (4) add_op(OP_POP, '1);
      directed_ops = pending_ops.size();
      while (pending_ops.size() < target) begin
         case ($urandom_range(0, 2))
            0: begin
               push_pct = 90;
               burst = $urandom_range(80, 140);
            end
            1: begin
               push_pct = 10;
               burst = $urandom_range(20, 100);
            end
            default: begin
               push_pct = 55;
               burst = $urandom_range(10, 80);
            end
         endcase
         if (burst > target - pending_ops.size()) burst = target - pending_ops.size();
         repeat (burst) begin
            if ($urandom_range(0, 99) < push_pct)
               add_op(OP_PUSH, draw_value());
            else
               add_op(OP_POP, data_type'($urandom));
         end
      end
      total_ops = pending_ops.size();
   endtask

   always @(posedge clock) begin : drive_ops
      rsp_beat_type r;
      logic accepted;
      int done_now;
      logic hold_off;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         gap_left <= '0;
      end else begin
         accepted = req_valid && req_ready;
         if (accepted) begin
            r = apply_op(req_data);
            pending_reports.push_back(r);
            if (req_data.req_type == OP_PUSH) push_count++;
            else pop_count++;
            if (r.status == STATUS_FULL) full_hits++;
            if (r.status == STATUS_EMPTY) empty_hits++;
            if (shadow_depth > deepest) deepest = shadow_depth;
            sent_count <= sent_count + 1;
         end
         done_now = sent_count + (accepted ? 1 : 0);
         hold_off = (done_now == directed_ops || done_now == total_ops / 2)
                    && rsp_count != done_now;
         if (req_valid && !req_ready) begin
            // hold
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1'b1;
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0 && !hold_off) begin
            req_data <= pending_ops.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_idle <= !send_idle;
            gap_left <= send_idle ? 4'($urandom_range(0, 8)) : 4'd0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      rsp_beat_type want;
      int next_stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= '0;
      end else begin
         next_stall = (stall_left != 0) ? stall_left - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (pending_reports.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected beat min %0d valid %0b depth %0d status %0d",
                           $time, rsp_data.min_value, rsp_data.min_valid,
                           rsp_data.depth, rsp_data.status);
            end else begin
               want = pending_reports.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     if (rsp_data.min_value !== want.min_value)
                        $display("%0t: min_value expected %0d got %0d",
                                 $time, want.min_value, rsp_data.min_value);
                     if (rsp_data.min_valid !== want.min_valid)
                        $display("%0t: min_valid expected %0b got %0b",
                                 $time, want.min_valid, rsp_data.min_valid);
                     if (rsp_data.depth !== want.depth)
                        $display("%0t: depth expected %0d got %0d",
                                 $time, want.depth, rsp_data.depth);
                     if (rsp_data.status !== want.status)
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp_data.status);
                  end
               end
            end
            if ($urandom_range(0, 39) == 0) take_idle <= !take_idle;
            next_stall = take_idle ? $urandom_range(0, 8) : 0;
         end
         stall_left <= 4'(next_stall);
         rsp_ready <= (next_stall == 0);
      end
   end

   initial begin
      build_ops(1150);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (sent_count < total_ops) @(posedge clock);
      while (rsp_count < total_ops) @(posedge clock);
      repeat (HOLD_TAIL) @(posedge clock);
      if (pending_reports.size() != 0) begin
         errors++;
         $display("%0t: %0d expected beats never arrived", $time, pending_reports.size());
      end
      $display("Ran %0d operations: %0d pushes, %0d pops, deepest stack %0d of %0d.",
               total_ops, push_count, pop_count, deepest, STACK_DEPTH);
      $display("Pushes dropped on a full stack: %0d, pops of an empty stack: %0d.",
               full_hits, empty_hits);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
